// ----- rtl/core/page_framebuffer_bitmap_blit_core_assert.svh -----
// Assertion macros used by the blit core RTL.
`ifndef PAGE_FRAMEBUFFER_BITMAP_BLIT_CORE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_BITMAP_BLIT_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PBB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PBB_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/core/pbb_pkg.sv -----
package pbb_pkg;

   // Frame geometry.
   localparam int FRAME_PAGES   = 8;
   localparam int FRAME_COLUMNS = 128;

   localparam int COL_AW  = $clog2(FRAME_COLUMNS);
   localparam int PAGE_AW = (FRAME_PAGES > 1) ? $clog2(FRAME_PAGES) : 1;
   localparam int WORD_W  = FRAME_PAGES * 8;

   // Signed destination column (-128..254) and page (-8..15) working widths.
   localparam int DCOL_W  = 10;
   localparam int DPAGE_W = 6;

   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_POSITION   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_POSITION   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITMAP_WIDTH = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITMAP_PAGES = 4'd3;

   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic signed [7:0] x_position;
      logic signed [6:0] y_position;
      logic [7:0]        bitmap_width;
      logic [3:0]        bitmap_pages;
   } pbb_cfg_type;

   // One decoded transaction as it sits in the merge stage.
   typedef struct packed {
      logic               mode;
      logic [7:0]         pixel_byte;
      logic [2:0]         shift;
      logic [COL_AW-1:0]  col_addr;
      logic [PAGE_AW-1:0] low_page;
      logic [PAGE_AW-1:0] spill_page;
      logic               low_en;
      logic               spill_en;
   } pbb_item_type;

endpackage

// ----- rtl/core/pbb_if.sv -----
interface pbb_req_if import pbb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] pixel_byte;
   logic [2:0] page_index;
   logic [6:0] column_index;

   modport source (output valid, mode, pixel_byte, page_index, column_index, input ready);
   modport sink (input valid, mode, pixel_byte, page_index, column_index, output ready);
endinterface

interface pbb_rsp_if import pbb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       written;

   modport source (output valid, read_data, written, input ready);
   modport sink (input valid, read_data, written, output ready);
endinterface

interface pbb_csr_if import pbb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [7:0]             data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pbb_csr_regs.sv -----
module pbb_csr_regs import pbb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pbb_csr_if.sink     csr,
   output pbb_cfg_type cfg
);

   pbb_cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_position   <= 8'sd0;
         cfg_ff.y_position   <= 7'sd0;
         cfg_ff.bitmap_width <= 8'd8;
         cfg_ff.bitmap_pages <= 4'd1;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_X_POSITION:   cfg_ff.x_position   <= csr.data;
            CSR_Y_POSITION:   cfg_ff.y_position   <= csr.data[6:0];
            CSR_BITMAP_WIDTH: cfg_ff.bitmap_width <= csr.data;
            CSR_BITMAP_PAGES: cfg_ff.bitmap_pages <= csr.data[3:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/core/pbb_frame_store.sv -----
module pbb_frame_store import pbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [COL_AW-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_word,
   input  logic              wr_en,
   input  logic [COL_AW-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_word
);

   // One word per column holds all pages of that column.
   logic [WORD_W-1:0]        frame_mem_ff [FRAME_COLUMNS];
   logic [FRAME_COLUMNS-1:0] col_valid_ff;
   logic [WORD_W-1:0]        rd_data_ff;
   logic                     rd_valid_ff;
   logic                     fwd_ff;
   logic [WORD_W-1:0]        fwd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff  <= frame_mem_ff[rd_addr];
         fwd_word_ff <= wr_word;
      end
   end

   // A column never written reads as zero; a write on the read edge is forwarded.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (wr_en) begin
            col_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= col_valid_ff[rd_addr];
            fwd_ff      <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_word = fwd_ff ? fwd_word_ff : (rd_valid_ff ? rd_data_ff : '0);

endmodule

// ----- rtl/core/pbb_merge.sv -----
module pbb_merge import pbb_pkg::*; (
   input  pbb_item_type      item,
   input  logic [WORD_W-1:0] old_word,
   output logic [WORD_W-1:0] new_word,
   output logic [7:0]        read_data,
   output logic              written
);

   logic [7:0] low_bits;
   logic [7:0] spill_bits;
   logic [7:0] low_keep;
   logic [3:0] spill_shift;

   assign low_keep    = ~(BYTE_MASK << item.shift);
   assign spill_shift = 4'd8 - {1'b0, item.shift};
   assign low_bits    = item.pixel_byte << item.shift;
   assign spill_bits  = item.pixel_byte >> spill_shift;
   assign written     = (item.mode == MODE_DRAW) && (item.low_en || item.spill_en);

   always_comb begin
      logic [7:0] old_byte;
      new_word  = old_word;
      read_data = 8'd0;
      for (int p = 0; p < FRAME_PAGES; p++) begin
         old_byte = old_word[p*8 +: 8];
         if (item.low_en && (item.low_page == PAGE_AW'(p))) begin
            if (item.mode == MODE_READ) begin
               read_data = old_byte;
            end else begin
               new_word[p*8 +: 8] = (old_byte & low_keep) | low_bits;
            end
         end
         if (item.spill_en && (item.spill_page == PAGE_AW'(p))) begin
            new_word[p*8 +: 8] = (old_byte & ~low_keep) | spill_bits;
         end
      end
   end

endmodule

// ----- rtl/core/page_framebuffer_bitmap_blit_core.sv -----
// Page-mode monochrome frame buffer with a bitmap blit port.
// The frame is FRAME_PAGES pages by FRAME_COLUMNS columns of bytes, each byte a
// vertical strip of eight pixels with bit 0 on top. A req transaction either draws
// one source bitmap byte at the position held in the csr registers (x, y, bitmap
// width and pages) or reads one frame byte. Every req transaction gives exactly one
// rsp transaction: read_data on a read, written on a draw.
// The frame is stored as one word per column holding all pages, so a draw that
// straddles two pages is a single read-modify-write of one word. The word is read
// on the accepting edge, merged in the next cycle and written back as the result
// is registered; a back-to-back transaction on the same column gets the new word
// forwarded. The block takes one transaction per cycle while rsp does not stall, and
// a result reaches rsp through the merge stage and then the rsp output register.
// The rsp side has its own output register, so the block keeps accepting while a
// result waits; when rsp stalls, the merge stage fills and then req_bus.ready drops.
// Reset clears the csr registers to their defaults and the per-column valid bits, so
// the whole frame reads as zero at once and no clearing pass is needed. The csr port
// is always ready; the user ensures registers are written only while the block is idle, unchecked.
`include "page_framebuffer_bitmap_blit_core_assert.svh"

module page_framebuffer_bitmap_blit_core import pbb_pkg::*; (
   input logic     clock,
   input logic     reset,
   pbb_req_if.sink   req_bus,
   pbb_rsp_if.source rsp_bus,
   pbb_csr_if.sink   csr_bus
);

   pbb_cfg_type       cfg;
   pbb_item_type      item_in;
   pbb_item_type      s1_item_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_adv;
   logic              req_accept;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_read_data_ff;
   logic              rsp_written_ff;
   logic [WORD_W-1:0] old_word;
   logic [WORD_W-1:0] new_word;
   logic [7:0]        merge_read_data;
   logic              merge_written;
   logic              wr_en;

   // Destination decode, done on the incoming transaction.
   logic                is_read;
   logic [DCOL_W-1:0]   col_ext;
   logic [DCOL_W-1:0]   x_ext;
   logic [DCOL_W-1:0]   dcol;
   logic [DPAGE_W-1:0]  pg_ext;
   logic [DPAGE_W-1:0]  y_page;
   logic [DPAGE_W-1:0]  dpage;
   logic [DPAGE_W-1:0]  spill_dpage;
   logic [2:0]          shift;
   logic                src_ok;
   logic                col_ok;

   pbb_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   assign is_read = (req_bus.mode == MODE_READ);
   assign col_ext = DCOL_W'(req_bus.column_index);
   assign x_ext   = {{(DCOL_W-8){cfg.x_position[7]}}, cfg.x_position};
   assign dcol    = is_read ? col_ext : (x_ext + col_ext);

   // floor(y / 8) is the arithmetic shift of y; y mod 8 is its low three bits.
   assign pg_ext      = DPAGE_W'(req_bus.page_index);
   assign y_page      = {{(DPAGE_W-4){cfg.y_position[6]}}, cfg.y_position[6:3]};
   assign dpage       = is_read ? pg_ext : (y_page + pg_ext);
   assign spill_dpage = dpage + DPAGE_W'(1);
   assign shift       = is_read ? 3'd0 : cfg.y_position[2:0];

   // Negative positions wrap to large unsigned values and fail the bound checks.
   assign src_ok = ({1'b0, req_bus.column_index} < cfg.bitmap_width) &&
                   ({1'b0, req_bus.page_index} < cfg.bitmap_pages);
   assign col_ok = (dcol < DCOL_W'(FRAME_COLUMNS));

   always_comb begin
      item_in.mode       = req_bus.mode;
      item_in.pixel_byte = req_bus.pixel_byte;
      item_in.shift      = shift;
      item_in.col_addr   = dcol[COL_AW-1:0];
      item_in.low_page   = dpage[PAGE_AW-1:0];
      item_in.spill_page = spill_dpage[PAGE_AW-1:0];
      item_in.low_en     = col_ok && (dpage < DPAGE_W'(FRAME_PAGES)) && (is_read || src_ok);
      item_in.spill_en   = !is_read && src_ok && col_ok && (shift != 3'd0) &&
                           (spill_dpage < DPAGE_W'(FRAME_PAGES));
   end

   // Merge stage advances when the output register is empty or being drained.
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !s1_valid_ff || s1_adv;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign s1_valid_in    = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in   = s1_adv || (rsp_valid_ff && !rsp_bus.ready);
   assign wr_en          = s1_adv && merge_written;

   pbb_frame_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (item_in.col_addr),
      .rd_word (old_word),
      .wr_en   (wr_en),
      .wr_addr (s1_item_ff.col_addr),
      .wr_word (new_word)
   );

   pbb_merge u_merge (
      .item      (s1_item_ff),
      .old_word  (old_word),
      .new_word  (new_word),
      .read_data (merge_read_data),
      .written   (merge_written)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= item_in;
      end
      if (s1_adv) begin
         rsp_read_data_ff <= merge_read_data;
         rsp_written_ff   <= merge_written;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_read_data_ff;
   assign rsp_bus.written   = rsp_written_ff;

   // The frame is only written by a draw that leaves the merge stage.
   `PBB_ASSERT_IMP(a_write_on_draw_advance, clock, reset, wr_en,
      s1_valid_ff && s1_adv && (s1_item_ff.mode == MODE_DRAW), "frame write without draw advance")
   // An accepted transaction always lands in the merge stage.
   `PBB_ASSERT_NXT(a_accept_fills_stage, clock, reset, req_accept,
      s1_valid_ff, "accepted transaction lost before merge stage")
   // A stalled merge stage keeps its transaction.
   `PBB_ASSERT_NXT(a_stage_holds_on_stall, clock, reset, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_item_ff), "merge stage changed while stalled")
   // A draw result never carries frame data.
   `PBB_ASSERT_IMP(a_draw_reads_zero, clock, reset, rsp_valid_ff && rsp_written_ff,
      rsp_read_data_ff == 8'd0, "draw result with nonzero read data")

endmodule

// ----- tb/tb_page_framebuffer_bitmap_blit_core.sv -----
module tb_page_framebuffer_bitmap_blit_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pbb_pkg::*;

   // Before a register write the driver waits until the block has been quiet for
   // SETTLE_CYCLES in a row, so nothing is still in flight.
   localparam int RESULT_LATENCY = 2;
   localparam int SETTLE_CYCLES  = RESULT_LATENCY + 2;
   localparam int RANDOM_ITEMS   = 1100;
   // Once fewer jobs than this remain, neither side starts a new idle burst.
   localparam int TAIL_JOBS      = 150;
   localparam int MAX_PRINTED    = 30;
   localparam int TIMEOUT_NS     = 3_000_000;

   typedef enum logic [1:0] {
      JOB_ITEM,
      JOB_CSR,
      JOB_PAUSE
   } job_kind_type;

   // One entry of the stimulus script: a draw or read transaction, a register write,
   // or a pause that holds the sender until every reply has come back.
   typedef struct {
      job_kind_type           kind;
      logic                   mode;
      logic [7:0]             pixel;
      logic [2:0]             page;
      logic [6:0]             column;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [7:0]             csr_data;
   } script_job_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       written;
   } frame_reply_type;

   logic clock;
   logic reset;

   pbb_req_if req_bus ();
   pbb_rsp_if rsp_bus ();
   pbb_csr_if csr_bus ();

   page_framebuffer_bitmap_blit_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the frame and of the placement registers, kept in step with the
   // block by applying every accepted transaction in order.
   logic [7:0]        frame_bytes [FRAME_PAGES][FRAME_COLUMNS] = '{default: 8'h00};
   logic signed [7:0] place_x   = 8'sd0;
   logic signed [6:0] place_y   = 7'sd0;
   logic [7:0]        map_width = 8'd8;
   logic [3:0]        map_pages = 4'd1;

   script_job_type  blit_script[$];
   frame_reply_type awaited_replies[$];

   int error_count;
   int items_scripted;
   int in_flight;
   int settle_count;
   int send_gap;
   int send_pct;
   int send_phase_left;
   int take_stall;
   int take_pct;
   int take_phase_left;
   int draws_seen;
   int draws_landed;
   int reads_seen;
   int csr_seen;
   logic quiet_tail;

   // Placement that the script generator believes is active, used to aim reads at
   // bytes that draws have just touched.
   int gen_x = 0;
   int gen_y = 0;
   int gen_w = 8;
   int gen_p = 1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every input of the block holds a known value from time zero. Reset starts high
   // and is then released for good.
   initial begin
      reset                = 1'b1;
      quiet_tail           = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_DRAW;
      req_bus.pixel_byte   = 8'h00;
      req_bus.page_index   = 3'd0;
      req_bus.column_index = 7'd0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_X_POSITION;
      csr_bus.data         = 8'h00;
      rsp_bus.ready        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_page_framebuffer_bitmap_blit_core: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   // Applies one draw or read to the shadow frame and returns the reply the block
   // must give. A draw places the source byte at column x + column and at page
   // floor(y / 8) + page, shifted down by y mod 8. The low part replaces the upper
   // bits of that byte and the spill replaces the lower bits of the byte one page
   // further down; either part is dropped when it falls outside the frame.
   function automatic frame_reply_type blit_and_fetch(input logic mode, input logic [7:0] pix,
         input logic [2:0] pg, input logic [6:0] col);
      frame_reply_type reply;
      int row_base;
      int shift;
      int dest_col;
      int dest_page;
      logic [7:0] upper_mask;
      reply = '0;
      if (mode == MODE_READ) begin
         if (int'(pg) < FRAME_PAGES && int'(col) < FRAME_COLUMNS) begin
            reply.read_data = frame_bytes[pg][col];
         end
         return reply;
      end
      // Source bytes outside the configured bitmap are dropped entirely.
      if (col >= map_width || pg >= map_pages) begin
         return reply;
      end
      // Biasing y by 64 keeps the division and remainder on non-negative values,
      // which gives a floor division and a shift in 0..7.
      row_base   = int'(place_y) + 64;
      shift      = row_base % 8;
      dest_page  = row_base / 8 - 8 + int'(pg);
      dest_col   = int'(place_x) + int'(col);
      upper_mask = 8'hFF << shift;
      if (dest_col >= 0 && dest_col < FRAME_COLUMNS) begin
         if (dest_page >= 0 && dest_page < FRAME_PAGES) begin
            frame_bytes[3'(dest_page)][7'(dest_col)] =
               (frame_bytes[3'(dest_page)][7'(dest_col)] & ~upper_mask) | (pix << shift);
            reply.written = 1'b1;
         end
         // An aligned row has no spill at all.
         if (shift != 0 && dest_page + 1 >= 0 && dest_page + 1 < FRAME_PAGES) begin
            frame_bytes[3'(dest_page + 1)][7'(dest_col)] =
               (frame_bytes[3'(dest_page + 1)][7'(dest_col)] & upper_mask) |
               (pix >> (8 - shift));
            reply.written = 1'b1;
         end
      end
      return reply;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] index,
         input logic [7:0] data);
      case (index)
         CSR_X_POSITION:   place_x = data;
         CSR_Y_POSITION:   place_y = data[6:0];
         CSR_BITMAP_WIDTH: map_width = data;
         CSR_BITMAP_PAGES: map_pages = data[3:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 10;
         2:       return 25;
         default: return 50;
      endcase
   endfunction

   function automatic void queue_item(input logic mode, input logic [7:0] pix,
         input logic [2:0] pg, input logic [6:0] col);
      blit_script.push_back('{kind: JOB_ITEM, mode: mode, pixel: pix, page: pg, column: col,
                              csr_index: CSR_X_POSITION, csr_data: 8'h00});
      items_scripted++;
   endfunction

   function automatic void queue_csr(input logic [CSR_INDEX_W-1:0] index,
         input logic [7:0] data);
      blit_script.push_back('{kind: JOB_CSR, mode: MODE_DRAW, pixel: 8'h00, page: 3'd0,
                              column: 7'd0, csr_index: index, csr_data: data});
   endfunction

   function automatic void queue_pause();
      blit_script.push_back('{kind: JOB_PAUSE, mode: MODE_DRAW, pixel: 8'h00, page: 3'd0,
                              column: 7'd0, csr_index: CSR_X_POSITION, csr_data: 8'h00});
   endfunction

   // Writes all four placement registers. The bits above each register's width are
   // random so that every bit of the write data toggles.
   function automatic void queue_placement(input int x, input int y, input int w, input int p);
      queue_csr(CSR_X_POSITION, 8'(x));
      queue_csr(CSR_Y_POSITION, {1'($urandom), 7'(y)});
      queue_csr(CSR_BITMAP_WIDTH, 8'(w));
      queue_csr(CSR_BITMAP_PAGES, {4'($urandom), 4'(p)});
      gen_x = x;
      gen_y = y;
      gen_w = w;
      gen_p = p;
   endfunction

   // Script builder and end of run. The directed part walks the special cases; the
   // random part runs in phases, each with a fresh placement followed by a burst of
   // mostly well-formed draws inside the bitmap and reads aimed at what they touched.
   initial begin : run_script
      int random_target;
      int phase;
      int burst;
      int n;
      int pick;
      int col_hi;
      int page_hi;
      int aim_col;
      int aim_page;
      logic [2:0] pg;
      logic [6:0] col;

      // Reset placement: an 8 by 8 bitmap at the origin, aligned rows.
      queue_item(MODE_READ, 8'h00, 3'd0, 7'd0);
      queue_item(MODE_DRAW, 8'hFF, 3'd0, 7'd0);
      queue_item(MODE_DRAW, 8'h81, 3'd0, 7'd7);
      queue_item(MODE_DRAW, 8'h55, 3'd0, 7'd8);
      queue_item(MODE_DRAW, 8'hAA, 3'd1, 7'd0);
      queue_item(MODE_READ, 8'hFF, 3'd0, 7'd0);
      queue_item(MODE_READ, 8'h00, 3'd0, 7'd7);
      queue_item(MODE_READ, 8'h00, 3'd7, 7'd127);

      // Left edge just off the frame and a row offset of three, so draws split into a
      // low part and a spill, and the bottom page loses its spill.
      queue_csr(CSR_X_POSITION, 8'hFE);
      queue_csr(CSR_Y_POSITION, 8'h03);
      queue_csr(CSR_BITMAP_WIDTH, 8'd128);
      queue_csr(CSR_BITMAP_PAGES, 8'd8);
      queue_item(MODE_DRAW, 8'hA5, 3'd0, 7'd1);
      queue_item(MODE_DRAW, 8'hC3, 3'd0, 7'd2);
      queue_item(MODE_DRAW, 8'h7E, 3'd7, 7'd127);
      queue_item(MODE_DRAW, 8'hFF, 3'd3, 7'd10);
      queue_item(MODE_READ, 8'h00, 3'd0, 7'd0);
      queue_item(MODE_READ, 8'h00, 3'd1, 7'd0);
      queue_item(MODE_READ, 8'h00, 3'd7, 7'd125);
      queue_item(MODE_READ, 8'h00, 3'd3, 7'd8);
      queue_item(MODE_READ, 8'h00, 3'd4, 7'd8);

      // Topmost row and rightmost column: everything lands above or right of the frame.
      queue_csr(CSR_Y_POSITION, 8'hC0);
      queue_csr(CSR_X_POSITION, 8'h7F);
      queue_item(MODE_DRAW, 8'hFF, 3'd0, 7'd0);
      queue_item(MODE_DRAW, 8'hFF, 3'd7, 7'd0);
      queue_item(MODE_DRAW, 8'hFF, 3'd7, 7'd1);

      // Four rows above the frame: only the spill reaches page zero.
      queue_csr(CSR_X_POSITION, 8'h00);
      queue_csr(CSR_Y_POSITION, 8'h7C);
      queue_csr(CSR_INDEX_W'(15), 8'hFF);
      queue_csr(CSR_INDEX_W'(12), 8'h3C);
      queue_item(MODE_DRAW, 8'hF0, 3'd0, 7'd3);
      queue_item(MODE_READ, 8'h00, 3'd0, 7'd3);

      random_target = items_scripted + RANDOM_ITEMS;
      for (phase = 0; items_scripted < random_target; phase++) begin
         case (phase)
            0: queue_placement(-128, -64, 255, 15);
            1: queue_placement(127, 63, 1, 1);
            2: queue_placement(0, -1, 128, 8);
            3: queue_placement(-1, 7, 0, 0);
            4: queue_placement(5, -9, 128, 8);
            default: begin
               pick = $urandom_range(99);
               if (pick < 5) begin
                  col_hi = 0;
               end else if (pick < 15) begin
                  col_hi = $urandom_range(129, 255);
               end else if (pick < 25) begin
                  col_hi = 128;
               end else begin
                  col_hi = $urandom_range(1, 40);
               end
               pick = $urandom_range(99);
               if (pick < 5) begin
                  page_hi = 0;
               end else if (pick < 12) begin
                  page_hi = $urandom_range(9, 15);
               end else begin
                  page_hi = $urandom_range(1, 8);
               end
               queue_placement(int'($urandom_range(136)) - 16, int'($urandom_range(79)) - 16,
                               col_hi, page_hi);
            end
         endcase
         // Writes to indexes past the last register must change nothing.
         if ($urandom_range(99) < 15) begin
            queue_csr(CSR_INDEX_W'($urandom_range(4, 15)), 8'($urandom));
         end

         burst = $urandom_range(30, 80);
         for (n = 0; n < burst; n++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               // Well-formed draw: a source byte inside the configured bitmap.
               col_hi  = (gen_w == 0 || gen_w > 128) ? 127 : gen_w - 1;
               page_hi = (gen_p == 0 || gen_p > 8) ? 7 : gen_p - 1;
               col = 7'($urandom_range(col_hi));
               pg  = 3'($urandom_range(page_hi));
               aim_col  = gen_x + int'(col);
               aim_page = ((gen_y + 64) >> 3) - 8 + int'(pg);
               if ((gen_y & 7) != 0 && $urandom_range(1) == 1) begin
                  aim_page++;
               end
               queue_item(MODE_DRAW, 8'($urandom), pg, col);
            end else if (pick < 72) begin
               queue_item(MODE_DRAW, 8'($urandom), 3'($urandom), 7'($urandom));
            end else if (pick < 97) begin
               if (aim_col >= 0 && aim_col < FRAME_COLUMNS && aim_page >= 0 &&
                     aim_page < FRAME_PAGES && $urandom_range(99) < 75) begin
                  queue_item(MODE_READ, 8'($urandom), 3'(aim_page), 7'(aim_col));
               end else begin
                  queue_item(MODE_READ, 8'($urandom), 3'($urandom), 7'($urandom));
               end
            end else begin
               queue_pause();
            end
         end
      end

      // Let the driver drain the script, then wait for the last replies.
      while (blit_script.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      while (in_flight != 0 || req_bus.valid || csr_bus.valid) @(posedge clock);
      repeat (RESULT_LATENCY + 4) @(posedge clock);

      if (awaited_replies.size() != 0) begin
         report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
      end
      $display("Covered %0d draws (%0d changed the frame) and %0d reads", draws_seen,
               draws_landed, reads_seen);
      $display("across %0d register writes and %0d placement phases, %0d mismatches.",
               csr_seen, phase, error_count);
      if (error_count == 0) begin
         $display("tb_page_framebuffer_bitmap_blit_core: done, clean");
      end else begin
         $display("tb_page_framebuffer_bitmap_blit_core: done, errors");
      end
      $finish;
   end

   // Transactions accepted but not yet answered. Updated only from sampled handshakes,
   // so the driver reads the same value whatever order the blocks run in.
   always @(posedge clock) begin
      if (reset) begin
         in_flight <= 0;
      end else begin
         in_flight <= in_flight + int'(req_bus.valid && req_bus.ready)
                      - int'(rsp_bus.valid && rsp_bus.ready);
      end
   end

   // Driver. Takes jobs from the script in order. Item jobs go out on req after an
   // optional random idle burst. Register writes and pauses wait until nothing has
   // been in flight for SETTLE_CYCLES, so registers only change while the block idles.
   always @(posedge clock) begin : drive_jobs
      script_job_type job;
      logic req_free;
      logic csr_free;
      logic next_req_valid;
      logic next_csr_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         quiet_tail    <= 1'b0;
         settle_count  = 0;
         send_gap      = 0;
      end else begin
         req_free       = !req_bus.valid || req_bus.ready;
         csr_free       = !csr_bus.valid || csr_bus.ready;
         next_req_valid = !req_free;
         next_csr_valid = !csr_free;
         if (in_flight == 0 && !req_bus.valid && !csr_bus.valid) begin
            settle_count++;
         end else begin
            settle_count = 0;
         end
         // The idle rate changes after each random-length phase, zero among the choices, so
         // the run has both busy stretches and stretches full of gaps.
         if (send_phase_left == 0) begin
            send_pct        = pick_idle_pct();
            send_phase_left = $urandom_range(20, 120);
         end else begin
            send_phase_left--;
         end
         if (req_free && csr_free && blit_script.size() != 0) begin
            job = blit_script[0];
            if (job.kind == JOB_ITEM) begin
               if (send_gap > 0) begin
                  send_gap--;
               end else if (!quiet_tail && $urandom_range(99) < send_pct) begin
                  send_gap = $urandom_range(1, 9) - 1;
               end else begin
                  req_bus.mode         <= job.mode;
                  req_bus.pixel_byte   <= job.pixel;
                  req_bus.page_index   <= job.page;
                  req_bus.column_index <= job.column;
                  next_req_valid = 1'b1;
                  void'(blit_script.pop_front());
               end
            end else if (settle_count >= SETTLE_CYCLES) begin
               if (job.kind == JOB_CSR) begin
                  csr_bus.index <= job.csr_index;
                  csr_bus.data  <= job.csr_data;
                  next_csr_valid = 1'b1;
               end
               void'(blit_script.pop_front());
            end
         end
         quiet_tail    <= (blit_script.size() < TAIL_JOBS);
         req_bus.valid <= next_req_valid;
         csr_bus.valid <= next_csr_valid;
      end
   end

   // Receiver. Stalls rsp in random bursts, with its own changing stall rate, and
   // stops stalling once the run reaches its tail.
   always @(posedge clock) begin : accept_replies
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_stall = 0;
      end else begin
         if (take_phase_left == 0) begin
            take_pct        = pick_idle_pct();
            take_phase_left = $urandom_range(20, 120);
         end else begin
            take_phase_left--;
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(99) < take_pct) begin
            take_stall = $urandom_range(1, 9) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor. Register writes and req transactions update the shadow state in the
   // order the block accepts them; each rsp transaction is checked against the
   // oldest predicted reply.
   always @(posedge clock) begin : check_replies
      frame_reply_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            apply_register(csr_bus.index, csr_bus.data);
            csr_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            want = blit_and_fetch(req_bus.mode, req_bus.pixel_byte, req_bus.page_index,
                                  req_bus.column_index);
            awaited_replies.push_back(want);
            if (req_bus.mode == MODE_READ) begin
               reads_seen++;
            end else begin
               draws_seen++;
               draws_landed += int'(want.written);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("reply arrived with no transaction outstanding");
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_bus.read_data !== want.read_data) begin
                  report_mismatch($sformatf("read_data %02h, expected %02h",
                                            rsp_bus.read_data, want.read_data));
               end
               if (rsp_bus.written !== want.written) begin
                  report_mismatch($sformatf("written %b, expected %b",
                                            rsp_bus.written, want.written));
               end
            end
         end
      end
   end

endmodule

// ----- page_framebuffer_bitmap_blit_core.f -----
+incdir+rtl/core
rtl/core/pbb_pkg.sv
rtl/core/pbb_if.sv
rtl/core/pbb_csr_regs.sv
rtl/core/pbb_frame_store.sv
rtl/core/pbb_merge.sv
rtl/core/page_framebuffer_bitmap_blit_core.sv
tb/tb_page_framebuffer_bitmap_blit_core.sv
